/* sv/mrr_pkg.sv */
// shared types and constants for the miller-rabin round block
// no dependencies
package mrr_pkg;

  localparam logic [1:0] VerdictPrime     = 2'd0;
  localparam logic [1:0] VerdictComposite = 2'd1;
  localparam logic [1:0] VerdictEven      = 2'd2;
  localparam logic [1:0] VerdictTwo       = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,
    OpSplitInit,   // exp = n-1, s = 0
    OpSplitStep,   // exp >>= 1, s += 1
    OpRedInit,     // start a mod n, res = 1
    OpRedStep,     // one restoring step of a mod n
    OpMulResSq,    // load res*sq into res
    OpMulSqSq,     // load sq*sq into sq
    OpMulResRes,   // load res*res into res, s -= 1
    OpMulStep,     // one shift-and-add step of the multiply
    OpShiftExp     // exp >>= 1
  } op_e;

  typedef struct packed {
    logic       n_two;
    logic       n_bad;
    logic       unit_done;
    logic       exp_zero;
    logic       exp_lsb;
    logic       res_one;
    logic       res_nm1;
    logic       s_one;
  } sts_t;

endpackage

/* sv/miller_rabin_round_64.sv */
// miller-rabin single round top level over mrr_ctrl and mrr_datapath (mrr_pkg)
// n equal to 2, even n and n below 2 are decided without arithmetic; odd n runs
// the reduction of a mod n, square and multiply over the k bits and p ones of d,
// then t < s squarings, s the power of two in n-1; each product is WIDTH serial steps
// one transaction at a time, next start taken while done_o is high; no stall
// reset is asynchronous active low and clears every register
module miller_rabin_round_64 #(
  parameter int WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] candidate_i,
  input  logic [63:0] witness_base_i,
  output logic        done_o,
  output logic [1:0]  verdict_o
);
  import mrr_pkg::*;

  op_e  cmd;
  sts_t sts;

  mrr_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o,
    .verdict_o, .cmd_o(cmd), .sts_i(sts)
  );

  mrr_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .rst_ni, .candidate_i, .witness_base_i, .cmd_i(cmd), .sts_o(sts)
  );

endmodule

/* sv/mrr_datapath.sv */
// datapath: operand registers, serial modular reduce and multiply
// depends on mrr_pkg
module mrr_datapath #(
  parameter int WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   candidate_i,
  input  logic [63:0]   witness_base_i,
  input  mrr_pkg::op_e  cmd_i,
  output mrr_pkg::sts_t sts_o
);
  import mrr_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n_q, a_q, res_q, sq_q, exp_q, acc_q, mop_q, y_q, rem_q;
  logic [CW-1:0]    cnt_q, s_q;
  logic             msel_q;

  // modular add helper, x and y below n
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] room;
    room = m - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  logic [WIDTH-1:0] dbl, acc_next, rem_next;
  logic [WIDTH:0]   rem_sh, rem_dif;
  always_comb begin
    dbl      = add_mod(acc_q, acc_q, n_q);
    acc_next = y_q[WIDTH-1] ? add_mod(dbl, mop_q, n_q) : dbl;
    // restoring remainder step for a mod n
    rem_sh   = {rem_q, a_q[WIDTH-1]};
    rem_dif  = rem_sh - {1'b0, n_q};
    rem_next = (rem_sh >= {1'b0, n_q}) ? rem_dif[WIDTH-1:0] : rem_sh[WIDTH-1:0];
  end

  // register updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      a_q    <= '0;
      res_q  <= '0;
      sq_q   <= '0;
      exp_q  <= '0;
      acc_q  <= '0;
      mop_q  <= '0;
      y_q    <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      s_q    <= '0;
      msel_q <= 1'b0;
    end else begin
      case (cmd_i)
        OpLoad: begin
          n_q <= candidate_i[WIDTH-1:0];
          a_q <= witness_base_i[WIDTH-1:0];
        end
        OpSplitInit: begin
          exp_q <= n_q - WIDTH'(1);
          s_q   <= '0;
        end
        OpSplitStep: begin
          exp_q <= exp_q >> 1;
          s_q   <= s_q + CW'(1);
        end
        OpRedInit: begin
          rem_q <= '0;
          cnt_q <= CW'(WIDTH);
          res_q <= WIDTH'(1);
        end
        OpRedStep: begin
          rem_q <= rem_next;
          a_q   <= {a_q[WIDTH-2:0], 1'b0};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) sq_q <= rem_next;
        end
        OpMulResSq: begin
          acc_q  <= '0;
          cnt_q  <= CW'(WIDTH);
          msel_q <= 1'b0;
          mop_q  <= sq_q;
          y_q    <= res_q;
        end
        OpMulSqSq: begin
          acc_q  <= '0;
          cnt_q  <= CW'(WIDTH);
          msel_q <= 1'b1;
          mop_q  <= sq_q;
          y_q    <= sq_q;
        end
        OpMulResRes: begin
          acc_q  <= '0;
          cnt_q  <= CW'(WIDTH);
          msel_q <= 1'b0;
          mop_q  <= res_q;
          y_q    <= res_q;
          s_q    <= s_q - CW'(1);
        end
        OpMulStep: begin
          acc_q <= acc_next;
          y_q   <= {y_q[WIDTH-2:0], 1'b0};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            if (msel_q) sq_q <= acc_next;
            else res_q <= acc_next;
          end
        end
        OpShiftExp: begin
          exp_q <= exp_q >> 1;
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts_o.n_two     = (n_q == WIDTH'(2));
    sts_o.n_bad     = (n_q < WIDTH'(2)) || !n_q[0];
    sts_o.unit_done = (cnt_q == CW'(1));
    sts_o.exp_zero  = (exp_q == '0);
    sts_o.exp_lsb   = exp_q[0];
    sts_o.res_one   = (res_q == WIDTH'(1));
    sts_o.res_nm1   = (res_q == n_q - WIDTH'(1));
    sts_o.s_one     = (s_q == CW'(1));
  end

endmodule

/* sv/mrr_ctrl.sv */
// controller: sequences reduction, exponentiation and squaring chain
// depends on mrr_pkg
module mrr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [1:0]    verdict_o,
  output mrr_pkg::op_e  cmd_o,
  input  mrr_pkg::sts_t sts_i
);
  import mrr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_RED   = 4'd3;
  localparam logic [3:0] S_EXP   = 4'd4;
  localparam logic [3:0] S_MULR  = 4'd5;
  localparam logic [3:0] S_SQI   = 4'd6;
  localparam logic [3:0] S_MULS  = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_TEST  = 4'd9;
  localparam logic [3:0] S_SQX   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       done_q, done_d;
  logic [1:0] verdict_q, verdict_d;

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign verdict_o = verdict_q;

  // next state and commands
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    verdict_d = verdict_q;
    cmd_o     = OpNone;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = OpLoad;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.n_two) begin
          verdict_d = VerdictTwo; done_d = 1'b1; state_d = S_IDLE;
        end else if (sts_i.n_bad) begin
          verdict_d = VerdictEven; done_d = 1'b1; state_d = S_IDLE;
        end else begin
          cmd_o = OpSplitInit; state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // strip factors of two from n-1
        if (sts_i.exp_lsb) begin
          cmd_o = OpRedInit; state_d = S_RED;
        end else begin
          cmd_o = OpSplitStep;
        end
      end
      S_RED: begin
        cmd_o = OpRedStep;
        if (sts_i.unit_done) state_d = S_EXP;
      end
      S_EXP: begin
        // square and multiply, lsb first; a^d equal to one passes at once
        if (sts_i.exp_zero) begin
          if (sts_i.res_one) begin
            verdict_d = VerdictPrime; done_d = 1'b1; state_d = S_IDLE;
          end else begin
            state_d = S_TEST;
          end
        end else if (sts_i.exp_lsb) begin
          cmd_o = OpMulResSq; state_d = S_MULR;
        end else begin
          cmd_o = OpMulSqSq; state_d = S_MULS;
        end
      end
      S_MULR: begin
        cmd_o = OpMulStep;
        if (sts_i.unit_done) state_d = S_SQI;
      end
      S_SQI: begin
        cmd_o = OpMulSqSq; state_d = S_MULS;
      end
      S_MULS: begin
        cmd_o = OpMulStep;
        if (sts_i.unit_done) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o = OpShiftExp; state_d = S_EXP;
      end
      S_TEST: begin
        // squaring chain: at most s checks against n-1
        if (sts_i.res_nm1) begin
          verdict_d = VerdictPrime; done_d = 1'b1; state_d = S_IDLE;
        end else if (sts_i.s_one) begin
          verdict_d = VerdictComposite; done_d = 1'b1; state_d = S_IDLE;
        end else begin
          cmd_o = OpMulResRes; state_d = S_SQX;
        end
      end
      S_SQX: begin
        cmd_o = OpMulStep;
        if (sts_i.unit_done) state_d = S_TEST;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      verdict_q <= VerdictPrime;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      verdict_q <= verdict_d;
    end
  end

  // assertions
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= S_SQX) else $error("illegal state");

endmodule
